// ===== src/wme_pkg.sv =====
// Shared constants, codes and types of the word machine execute unit.
`default_nettype none

package wme_pkg;

	// Memory geometry and block sizes
	localparam int MEM_WORDS   = 100;
	localparam int BLOCK_WORDS = 10;
	localparam int MAX_RES     = 10;
	localparam int PD_N        = (BLOCK_WORDS < MAX_RES) ? BLOCK_WORDS : MAX_RES;
	localparam int ADDR_W      = 7;
	localparam int WORD_W      = 32;
	localparam int LEFT_W      = 5;
	localparam int K_W         = $clog2(PD_N + 1);

	localparam logic [ADDR_W-1:0] MEM_LIM  = ADDR_W'(MEM_WORDS);
	localparam logic [LEFT_W-1:0] BLK_CNT  = LEFT_W'(BLOCK_WORDS);
	localparam logic [K_W-1:0]    PD_LAST  = K_W'(PD_N - 1);
	localparam logic [WORD_W-1:0] SPACES   = 32'h2020_2020;

	// Item opcodes
	localparam logic [2:0] OP_CLEAR = 3'd0;
	localparam logic [2:0] OP_LOAD  = 3'd1;
	localparam logic [2:0] OP_START = 3'd2;
	localparam logic [2:0] OP_STEP  = 3'd3;
	localparam logic [2:0] OP_CARD  = 3'd4;

	// Result status codes
	localparam logic [2:0] STS_OK      = 3'd0;
	localparam logic [2:0] STS_HALT    = 3'd1;
	localparam logic [2:0] STS_NOTRUN  = 3'd2;
	localparam logic [2:0] STS_BADADDR = 3'd3;
	localparam logic [2:0] STS_AWAIT   = 3'd4;
	localparam logic [2:0] STS_UNEXP   = 3'd5;
	localparam logic [2:0] STS_REFUSE  = 3'd6;

	// ASCII characters of the instruction set
	localparam logic [7:0] CH_0 = 8'd48;
	localparam logic [7:0] CH_9 = 8'd57;
	localparam logic [7:0] CH_G = 8'h47;
	localparam logic [7:0] CH_D = 8'h44;
	localparam logic [7:0] CH_P = 8'h50;
	localparam logic [7:0] CH_H = 8'h48;
	localparam logic [7:0] CH_L = 8'h4C;
	localparam logic [7:0] CH_R = 8'h52;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_B = 8'h42;
	localparam logic [7:0] CH_T = 8'h54;

	// Sequencer states
	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EXEC  = 5'b00010,
		S_OPER  = 5'b00100,
		S_PD_RD = 5'b01000,
		S_PD_WR = 5'b10000
	} state_t;

endpackage

`default_nettype wire

// ===== src/word_machine_execute_unit.sv =====
// Top level: sequencer of the word machine around its word memory.
//
// Usage: one input channel (in_valid/in_ready with opcode, address,
// data_word) and one result channel (out_valid/out_ready with status,
// out_word, word_valid, last, counter_now, flag_now, reg_now). Each item
// gives one result, except a PD step, which gives ten results, the last
// one marked by last.
// Sequence: an item transfers in the idle state, which also starts the read
// of the instruction word or card target; the result is registered from
// the execute state. An LR or CR step goes on to an operand state that
// reads the operand word; a PD step reads one memory word per result,
// alternating a read state and an output state. The sequencer takes a new
// item only when idle, after the steps of the last item.
// Clear memory drops the per-word valid bits at once, and
// a word that is not valid reads as four spaces.
// Reset: memory reads as spaces, the register holds spaces, the counter and
// flag are zero and the machine is halted. No clearing pass is needed.
// Stall: results wait in an output register; while it is full and not
// taken, one more item may transfer, then the sequencer holds in its
// execute step until the register frees.
`default_nettype none

module word_machine_execute_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [2:0]                   opcode,
	input  wire logic [wme_pkg::ADDR_W-1:0]   address,
	input  wire logic [wme_pkg::WORD_W-1:0]   data_word,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [2:0]                   status,
	output logic      [wme_pkg::WORD_W-1:0]   out_word,
	output logic                              word_valid,
	output logic                              last,
	output logic      [wme_pkg::ADDR_W-1:0]   counter_now,
	output logic                              flag_now,
	output logic      [wme_pkg::WORD_W-1:0]   reg_now
);

	import wme_pkg::*;

	state_t state_q, state_d;

	// Architectural state
	logic [ADDR_W-1:0] ic_q, ic_d;
	logic              tog_q, tog_d;
	logic [WORD_W-1:0] gp_q, gp_d;
	logic              halt_q, halt_d;
	logic              cact_q, cact_d;
	logic [ADDR_W-1:0] caddr_q, caddr_d;
	logic [LEFT_W-1:0] cleft_q, cleft_d;
	logic [MEM_WORDS-1:0] valid_q;

	// Latched item and operand
	logic [2:0]        op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [WORD_W-1:0] data_q;
	logic [ADDR_W-1:0] opr_q;
	logic              sel_cr_q;
	logic              rvld_q;
	logic [K_W-1:0]    k_q, k_d;

	// Memory port
	logic              rd_en, wr_en, clr_all;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic [WORD_W-1:0] wr_data, rd_data, mem_word;

	// Output register
	logic              out_valid_q, out_load, out_free;
	logic [2:0]        res_status;
	logic [WORD_W-1:0] res_word;
	logic              res_wvalid, res_last;

	// Instruction decode
	logic [7:0]        b0, b1, hi, lo;
	logic              digits_ok, opr_ok, known;
	logic              is_gd, is_pd, is_lr, is_sr, is_cr, is_bt;
	logic [ADDR_W-1:0] opr_a, pd_a;
	logic [WORD_W-1:0] merged;
	logic [2:0]        card_sts;

	wme_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MEM_WORDS)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// A word never written since reset or clear reads as spaces
	assign mem_word = rvld_q ? rd_data : SPACES;

	assign in_ready  = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Decode the fetched word
	always_comb begin
		b0 = mem_word[31:24];
		b1 = mem_word[23:16];
		hi = mem_word[15:8];
		lo = mem_word[7:0];
		digits_ok = (hi inside {[CH_0:CH_9]}) && (lo inside {[CH_0:CH_9]});
		opr_a = ADDR_W'({hi[3:0], 3'b000}) + ADDR_W'({hi[3:0], 1'b0}) + ADDR_W'(lo[3:0]);
		opr_ok = digits_ok && (opr_a < MEM_LIM);
		is_gd = (b0 == CH_G) && (b1 == CH_D);
		is_pd = (b0 == CH_P) && (b1 == CH_D);
		is_lr = (b0 == CH_L) && (b1 == CH_R);
		is_sr = (b0 == CH_S) && (b1 == CH_R);
		is_cr = (b0 == CH_C) && (b1 == CH_R);
		is_bt = (b0 == CH_B) && (b1 == CH_T);
		known = is_gd || is_pd || is_lr || is_sr || is_cr || is_bt;
		pd_a  = opr_q + ADDR_W'(k_q);
	end

	// Merge a card word: a zero byte keeps the stored byte
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			merged[8*i +: 8] = (data_q[8*i +: 8] == 8'd0) ? mem_word[8*i +: 8]
				: data_q[8*i +: 8];
		end
	end

	// Sequencer
	always_comb begin
		state_d    = state_q;
		ic_d       = ic_q;
		tog_d      = tog_q;
		gp_d       = gp_q;
		halt_d     = halt_q;
		cact_d     = cact_q;
		caddr_d    = caddr_q;
		cleft_d    = cleft_q;
		k_d        = k_q;
		rd_en      = 1'b0;
		rd_addr    = '0;
		wr_en      = 1'b0;
		wr_addr    = '0;
		wr_data    = gp_q;
		clr_all    = 1'b0;
		out_load   = 1'b0;
		res_status = STS_OK;
		res_word   = '0;
		res_wvalid = 1'b0;
		res_last   = 1'b1;
		card_sts   = STS_OK;
		case (state_q)
			S_IDLE: begin
				// Fetch the instruction or the old card target with the transfer
				rd_addr = (opcode == OP_STEP) ? ic_q : caddr_q;
				if (in_valid) begin
					rd_en   = (rd_addr < MEM_LIM);
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
					case (op_q)
						OP_CLEAR: begin
							clr_all = 1'b1;
							gp_d    = SPACES;
							halt_d  = 1'b1;
							cact_d  = 1'b0;
							cleft_d = '0;
						end
						OP_LOAD: begin
							if (addr_q < MEM_LIM) begin
								wr_en   = 1'b1;
								wr_addr = addr_q;
								wr_data = data_q;
							end else begin
								res_status = STS_BADADDR;
							end
						end
						OP_START: begin
							ic_d    = '0;
							halt_d  = 1'b0;
							cact_d  = 1'b0;
							cleft_d = '0;
						end
						OP_STEP: begin
							if (halt_q) begin
								res_status = STS_NOTRUN;
							end else if (cact_q) begin
								res_status = STS_REFUSE;
							end else if (ic_q >= MEM_LIM) begin
								halt_d     = 1'b1;
								res_status = STS_BADADDR;
							end else begin
								ic_d = ic_q + 1'b1;
								if (b0 == CH_H) begin
									halt_d     = 1'b1;
									res_status = STS_HALT;
								end else if (!known) begin
									res_status = STS_OK;
								end else if (!opr_ok) begin
									res_status = STS_BADADDR;
								end else if (is_gd) begin
									cact_d     = 1'b1;
									caddr_d    = opr_a;
									cleft_d    = BLK_CNT;
									res_status = STS_AWAIT;
								end else if (is_pd) begin
									out_load = 1'b0;
									k_d      = '0;
									state_d  = S_PD_RD;
								end else if (is_lr || is_cr) begin
									out_load = 1'b0;
									rd_en    = 1'b1;
									rd_addr  = opr_a;
									state_d  = S_OPER;
								end else if (is_sr) begin
									wr_en   = 1'b1;
									wr_addr = opr_a;
									wr_data = gp_q;
								end else if (tog_q) begin
									ic_d = opr_a;
								end
							end
						end
						OP_CARD: begin
							if (!cact_q) begin
								res_status = STS_UNEXP;
							end else begin
								if (caddr_q < MEM_LIM) begin
									wr_en   = 1'b1;
									wr_addr = caddr_q;
									wr_data = merged;
								end else begin
									card_sts = STS_BADADDR;
								end
								caddr_d = caddr_q + 1'b1;
								cleft_d = cleft_q - 1'b1;
								if (cleft_d == '0) begin
									cact_d = 1'b0;
								end else if (card_sts == STS_OK) begin
									card_sts = STS_AWAIT;
								end
								res_status = card_sts;
							end
						end
						default: begin
							res_status = STS_OK;
						end
					endcase
				end
			end
			S_OPER: begin
				// Finish LR or CR with the operand word
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
					if (sel_cr_q) begin
						tog_d = (mem_word == gp_q);
					end else begin
						gp_d = mem_word;
					end
				end
			end
			S_PD_RD: begin
				rd_addr = pd_a;
				rd_en   = (pd_a < MEM_LIM);
				state_d = S_PD_WR;
			end
			S_PD_WR: begin
				// Emit one printed word, then advance
				if (out_free) begin
					out_load = 1'b1;
					res_last = (k_q == PD_LAST);
					if (pd_a < MEM_LIM) begin
						res_word   = mem_word;
						res_wvalid = 1'b1;
					end else begin
						res_status = STS_BADADDR;
					end
					if (k_q == PD_LAST) begin
						state_d = S_IDLE;
					end else begin
						k_d     = k_q + 1'b1;
						state_d = S_PD_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control and architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ic_q        <= '0;
			tog_q       <= 1'b0;
			gp_q        <= SPACES;
			halt_q      <= 1'b1;
			cact_q      <= 1'b0;
			caddr_q     <= '0;
			cleft_q     <= '0;
			k_q         <= '0;
			valid_q     <= '0;
			rvld_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ic_q    <= ic_d;
			tog_q   <= tog_d;
			gp_q    <= gp_d;
			halt_q  <= halt_d;
			cact_q  <= cact_d;
			caddr_q <= caddr_d;
			cleft_q <= cleft_d;
			k_q     <= k_d;
			if (clr_all) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_q <= valid_q[rd_addr];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item, operand and result payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q   <= opcode;
			addr_q <= address;
			data_q <= data_word;
		end
		if (state_q == S_EXEC) begin
			opr_q    <= opr_a;
			sel_cr_q <= is_cr;
		end
		if (out_load) begin
			status      <= res_status;
			out_word    <= res_word;
			word_valid  <= res_wvalid;
			last        <= res_last;
			counter_now <= ic_d;
			flag_now    <= tog_d;
			reg_now     <= gp_d;
		end
	end

	// Checks
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q != S_IDLE))
		else $error("memory written outside of execution");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_EXEC))
		else $error("transfer did not start execution");

	a_pd_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PD_RD || state_q == S_PD_WR) |-> (k_q <= PD_LAST))
		else $error("print counter past block");

	a_word_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && word_valid) |-> (status == STS_OK))
		else $error("printed word with bad status");

endmodule

`default_nettype wire

// ===== src/wme_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module wme_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 100
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, and register the read word; hold it between reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire
